>>> hdl/time_table_message_scheduler_unit_macros.svh
// assertion macros for the time table message scheduler
// used by the checker module, no other dependencies
`ifndef TIME_TABLE_MESSAGE_SCHEDULER_UNIT_MACROS_SVH
`define TIME_TABLE_MESSAGE_SCHEDULER_UNIT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define TTMS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TTMS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ttms_pkg.sv
// types and codes of the time table message scheduler
// used by the top level and the checker, depends on nothing
package ttms_pkg;

	// input item modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// result events
	localparam logic [1:0] EV_NONE       = 2'd0;
	localparam logic [1:0] EV_SEND       = 2'd1;
	localparam logic [1:0] EV_MISS       = 2'd2;
	localparam logic [1:0] EV_ROUND_OVER = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_CATEGORIES = 2'd0;
	localparam logic [1:0] CFG_HYPER_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_START_SEQUENCE = 2'd2;

	// register reset values
	localparam logic [3:0]  NUM_CATEGORIES_RST = 4'd1;
	localparam logic [31:0] HYPER_PERIOD_RST   = 32'd1000000;
	localparam logic [31:0] START_SEQUENCE_RST = 32'd0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  category;
		logic [15:0] period_count;
		logic [15:0] message_limit;
		logic [31:0] now;
	} item_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [2:0]  chosen_category;
		logic [15:0] message_index;
		logic [31:0] sequence_number;
	} result_t;

endpackage

>>> hdl/time_table_message_scheduler_unit.sv
// time table message scheduler: sequencer, shared divider and category state
// depends on ttms_pkg
//
// channel  | direction | handshake             | payload
// item     | in        | item_valid/item_stall | ttms_pkg::item_t
// result   | out       | result_valid/result_stall | ttms_pkg::result_t
// cfg      | in        | cfg_we                | cfg_index, cfg_data
//
// one item at a time; a load runs the bit-serial divider (one quotient bit
// per cycle), a start steps through all n categories in use and a tick through
// up to n of them, one category compared per cycle
// reset clears the control state, the category windows, round end and counter
// the next item is taken while a result still waits behind result_stall
module time_table_message_scheduler_unit #(
	parameter int MAX_CATEGORIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ttms_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ttms_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	// at most 15 categories can ever be in use
	localparam int DEPTH = (MAX_CATEGORIES < 15) ? MAX_CATEGORIES : 15;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [3:0] DEPTH_N = 4'(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_ADV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]  state_q;
	logic [3:0]  num_cat_q;
	logic [31:0] hyper_q;
	logic [31:0] seq_cnt_q;
	logic [31:0] round_end_q;
	logic [31:0] now_q;
	logic [3:0]  cat_q;
	logic [2:0]  ld_cat_q;
	logic        ld_ok_q;
	logic [15:0] ld_lim_q;
	logic [15:0] div_rem_q;
	logic [31:0] div_quo_q;
	logic [15:0] div_d_q;
	logic [4:0]  div_cnt_q;
	ttms_pkg::result_t res_q;
	ttms_pkg::result_t out_q;
	logic        out_valid_q;

	logic [31:0] inc_tbl [DEPTH];
	logic [15:0] lim_tbl [DEPTH];
	logic [15:0] next_msg_q [DEPTH];
	logic [31:0] release_q [DEPTH];
	logic [31:0] deadline_q [DEPTH];

	logic        accept;
	logic [3:0]  n_eff;
	logic        cat_last;
	logic [IDX_W-1:0] cat_idx;
	logic [16:0] div_shift;
	logic        div_bit;
	logic [15:0] div_rem_next;
	logic [31:0] div_quo_next;
	logic        div_last;
	logic [31:0] cur_inc;
	logic [15:0] cur_lim;
	logic [15:0] cur_next;
	logic [31:0] cur_rel;
	logic [31:0] cur_dl;
	logic [15:0] nm_inc;
	logic        hit_miss;
	logic        hit_send;
	logic        out_free;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign n_eff      = (num_cat_q > DEPTH_N) ? DEPTH_N : num_cat_q;
	assign cat_last   = ((cat_q + 4'd1) == n_eff);
	assign cat_idx    = cat_q[IDX_W-1:0];
	assign out_free   = !out_valid_q || !result_stall;

	// one restoring divide step per cycle
	always_comb begin
		div_shift    = {div_rem_q, div_quo_q[31]};
		div_bit      = (div_shift >= {1'b0, div_d_q});
		div_rem_next = div_bit ? 16'(div_shift - {1'b0, div_d_q}) : div_shift[15:0];
		div_quo_next = {div_quo_q[30:0], div_bit};
		div_last     = (div_cnt_q == 5'd31);
	end

	// current category entry
	always_comb begin
		cur_inc  = inc_tbl[cat_idx];
		cur_lim  = lim_tbl[cat_idx];
		cur_next = next_msg_q[cat_idx];
		cur_rel  = release_q[cat_idx];
		cur_dl   = deadline_q[cat_idx];
		nm_inc   = cur_next + 16'd1;
		hit_miss = (now_q > cur_dl);
		hit_send = !hit_miss && (now_q > cur_rel);
	end

	// increment and limit tables, written at the end of a load
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_last && ld_ok_q) begin
			for (int e = 0; e < DEPTH; e++) begin
				if (int'(ld_cat_q) == e) begin
					inc_tbl[e] <= div_quo_next;
					lim_tbl[e] <= ld_lim_q;
				end
			end
		end
	end

	// category windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < DEPTH; e++) begin
				next_msg_q[e] <= '0;
				release_q[e]  <= '0;
				deadline_q[e] <= '0;
			end
		end else begin
			for (int e = 0; e < DEPTH; e++) begin
				if (cat_idx == IDX_W'(e)) begin
					if (state_q == ST_START) begin
						next_msg_q[e] <= '0;
						if (cur_lim == 16'd0) begin
							release_q[e]  <= round_end_q;
							deadline_q[e] <= round_end_q;
						end else begin
							release_q[e]  <= now_q;
							deadline_q[e] <= now_q + cur_inc;
						end
					end else if (state_q == ST_ADV) begin
						next_msg_q[e] <= nm_inc;
						if (nm_inc < cur_lim) begin
							release_q[e]  <= cur_dl + 32'd1;
							deadline_q[e] <= cur_dl + cur_inc;
						end else begin
							release_q[e]  <= round_end_q;
							deadline_q[e] <= round_end_q;
						end
					end
				end
			end
		end
	end

	// sequencer, registers and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_cat_q   <= ttms_pkg::NUM_CATEGORIES_RST;
			hyper_q     <= ttms_pkg::HYPER_PERIOD_RST;
			seq_cnt_q   <= ttms_pkg::START_SEQUENCE_RST;
			round_end_q <= '0;
			now_q       <= '0;
			cat_q       <= '0;
			ld_cat_q    <= '0;
			ld_ok_q     <= 1'b0;
			ld_lim_q    <= '0;
			div_rem_q   <= '0;
			div_quo_q   <= '0;
			div_d_q     <= '0;
			div_cnt_q   <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					ttms_pkg::CFG_NUM_CATEGORIES: num_cat_q <= cfg_data[3:0];
					ttms_pkg::CFG_HYPER_PERIOD:   hyper_q   <= cfg_data;
					ttms_pkg::CFG_START_SEQUENCE: seq_cnt_q <= cfg_data;
					default: ;
				endcase
			end

			// output register drains unless a new result replaces it
			if (out_valid_q && !result_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q <= item.now;
						cat_q <= '0;
						unique case (item.mode)
							ttms_pkg::MODE_LOAD: begin
								res_q     <= '0;
								ld_cat_q  <= item.category;
								ld_ok_q   <= (int'(item.category) < MAX_CATEGORIES);
								ld_lim_q  <= item.message_limit;
								div_rem_q <= '0;
								div_quo_q <= hyper_q;
								div_d_q   <= (item.period_count == 16'd0) ? 16'd1
									: item.period_count;
								div_cnt_q <= '0;
								state_q   <= ST_DIV;
							end
							ttms_pkg::MODE_START: begin
								res_q       <= '0;
								round_end_q <= item.now + hyper_q;
								state_q     <= (n_eff == 4'd0) ? ST_DONE : ST_START;
							end
							ttms_pkg::MODE_TICK: begin
								if (item.now >= round_end_q) begin
									res_q <= '{event_res: ttms_pkg::EV_ROUND_OVER,
										chosen_category: 3'd0, message_index: 16'd0,
										sequence_number: 32'd0};
									state_q <= ST_DONE;
								end else begin
									res_q   <= '0;
									state_q <= (n_eff == 4'd0) ? ST_DONE : ST_SCAN;
								end
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DIV: begin
					div_rem_q <= div_rem_next;
					div_quo_q <= div_quo_next;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_START: begin
					cat_q <= cat_q + 4'd1;
					if (cat_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (hit_miss || hit_send) begin
						res_q.event_res       <= hit_miss ? ttms_pkg::EV_MISS
							: ttms_pkg::EV_SEND;
						res_q.chosen_category <= cat_q[2:0];
						res_q.message_index   <= cur_next;
						if (hit_send) begin
							res_q.sequence_number <= seq_cnt_q;
							seq_cnt_q             <= seq_cnt_q + 32'd1;
						end
						state_q <= ST_ADV;
					end else if (cat_last) begin
						state_q <= ST_DONE;
					end else begin
						cat_q <= cat_q + 4'd1;
					end
				end
				ST_ADV: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> hdl/ttms_checker.sv
// port-level checks for the time table message scheduler, bound to the top level
// depends on ttms_pkg and time_table_message_scheduler_unit_macros.svh
`include "time_table_message_scheduler_unit_macros.svh"

module ttms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input ttms_pkg::result_t result
);

	logic item_take;
	logic res_held;
	logic res_no_send;
	logic res_seq_clear;
	logic res_no_cat;
	logic res_fields_clear;

	assign item_take        = item_valid && !item_stall;
	assign res_held         = result_valid && result_stall;
	assign res_no_send      = result_valid && (result.event_res != ttms_pkg::EV_SEND);
	assign res_seq_clear    = (result.sequence_number == 32'd0);
	assign res_no_cat       = result_valid && ((result.event_res == ttms_pkg::EV_NONE)
		|| (result.event_res == ttms_pkg::EV_ROUND_OVER));
	assign res_fields_clear = (result.chosen_category == 3'd0)
		&& (result.message_index == 16'd0);

	// a stalled result holds
	`TTMS_ASSERT(a_res_hold, clk, arst_n, res_held |=> $stable({result_valid, result}), "result moved")

	// every accepted item keeps the block busy in the following cycle
	`TTMS_ASSERT(a_busy_after_item, clk, arst_n, item_take |=> item_stall, "item taken back to back")

	// sequence number only on a send
	`TTMS_ASSERT(a_seq_only_send, clk, arst_n, res_no_send |-> res_seq_clear, "sequence without send")

	// no category on empty or round-over results
	`TTMS_ASSERT(a_no_cat_idle, clk, arst_n, res_no_cat |-> res_fields_clear, "category without event")

	// nothing is shown as a result during reset
	`TTMS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !result_valid, "result during reset")

endmodule

bind time_table_message_scheduler_unit ttms_checker u_ttms_checker (.*);

>>> test/tb_time_table_message_scheduler_unit.sv
`timescale 1ns / 1ps
// testbench of the time table message scheduler: directed table, then random rounds
// each result is checked against a typed expectation or an in-bench schedule predictor; depends on ttms_pkg
module tb_time_table_message_scheduler_unit;

	localparam int          SLOTS       = 8;
	localparam int          ITEMS       = 1800;
	localparam int          LONG_HOLD   = 300;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;

	typedef struct {
		bit                  is_cfg;
		logic [1:0]          cfg_sel;
		logic [31:0]         cfg_val;
		ttms_pkg::item_t     it;
		bit                  known;
		ttms_pkg::result_t   want;
	} table_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	ttms_pkg::item_t   item;
	logic    result_valid;
	logic    result_stall;
	ttms_pkg::result_t result;
	logic    cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// expectation typed into the directed table, travels with the item
	bit      item_known;
	ttms_pkg::result_t item_known_result;

	ttms_pkg::result_t expected_results [$];
	int      failures;
	int      offered;
	int      results_checked;
	int      phases;
	int      event_tally [4];
	int      cycles;

	// predictor state
	logic [3:0]  cat_used;
	logic [31:0] round_len;
	logic [31:0] seq_next;
	logic [31:0] round_stop;
	logic [31:0] cat_step  [SLOTS];
	logic [15:0] cat_quota [SLOTS];
	logic [15:0] msg_next  [SLOTS];
	logic [31:0] win_open  [SLOTS];
	logic [31:0] win_close [SLOTS];

	time_table_message_scheduler_unit #(
		.MAX_CATEGORIES(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// schedule predictor: works out the result of one accepted item
	function automatic ttms_pkg::result_t schedule_step(ttms_pkg::item_t it);
		ttms_pkg::result_t r;
		int n;
		int i;
		bit found;
		logic [31:0] divisor;
		r = '0;
		found = 1'b0;
		n = (cat_used > SLOTS) ? SLOTS : int'(cat_used);
		case (it.mode)
			ttms_pkg::MODE_LOAD: begin
				divisor = (it.period_count == 16'd0) ? 32'd1 : {16'd0, it.period_count};
				cat_step[it.category] = round_len / divisor;
				cat_quota[it.category] = it.message_limit;
			end
			ttms_pkg::MODE_START: begin
				round_stop = it.now + round_len;
				for (i = 0; i < n; i++) begin
					msg_next[i] = 16'd0;
					if (cat_quota[i] == 16'd0) begin
						win_open[i] = round_stop;
						win_close[i] = round_stop;
					end else begin
						win_open[i] = it.now;
						win_close[i] = it.now + cat_step[i];
					end
				end
			end
			ttms_pkg::MODE_TICK: begin
				if (it.now >= round_stop) begin
					r.event_res = ttms_pkg::EV_ROUND_OVER;
				end else begin
					for (i = 0; i < n && !found; i++) begin
						if (it.now > win_close[i]) begin
							r.event_res = ttms_pkg::EV_MISS;
						end else if (it.now > win_open[i]) begin
							r.event_res = ttms_pkg::EV_SEND;
							r.sequence_number = seq_next;
							seq_next = seq_next + 32'd1;
						end
						if (r.event_res != ttms_pkg::EV_NONE) begin
							found = 1'b1;
							r.chosen_category = i[2:0];
							r.message_index = msg_next[i];
							// move the window on, or close the category at its limit
							msg_next[i] = msg_next[i] + 16'd1;
							if (msg_next[i] < cat_quota[i]) begin
								win_open[i] = win_close[i] + 32'd1;
								win_close[i] = win_close[i] + cat_step[i];
							end else begin
								win_open[i] = round_stop;
								win_close[i] = round_stop;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// idle length: mostly none or short, a few long, with calm stretches
	function automatic int pick_gap(inout int calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 2) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic table_row_t item_row(logic [1:0] mode, logic [2:0] cat,
			logic [15:0] cnt, logic [15:0] lim, logic [31:0] now);
		table_row_t r;
		r = '{default: '0};
		r.it.mode = mode;
		r.it.category = cat;
		r.it.period_count = cnt;
		r.it.message_limit = lim;
		r.it.now = now;
		return r;
	endfunction

	function automatic table_row_t known(table_row_t row, logic [1:0] ev);
		table_row_t r;
		r = row;
		r.known = 1'b1;
		r.want = '0;
		r.want.event_res = ev;
		return r;
	endfunction

	function automatic table_row_t cfg_row(logic [1:0] sel, logic [31:0] val);
		table_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_sel = sel;
		r.cfg_val = val;
		return r;
	endfunction

	// offer one item, returns at the falling edge after it was taken
	int send_calm;
	task automatic offer_item(input ttms_pkg::item_t it, input bit is_known,
			input ttms_pkg::result_t want);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		item_known = is_known;
		item_known_result = want;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		if (it.mode != MODE_UNUSED)
			offered++;
	endtask

	// wait until every expected result has come back
	task automatic settle();
		item_valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		case (sel)
			ttms_pkg::CFG_NUM_CATEGORIES: cat_used = val[3:0];
			ttms_pkg::CFG_HYPER_PERIOD:   round_len = val;
			ttms_pkg::CFG_START_SEQUENCE: seq_next = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// predict each accepted item
	always @(posedge clk) begin : track_items
		ttms_pkg::result_t predicted;
		if (arst_n && item_valid && !item_stall) begin
			predicted = schedule_step(item);
			expected_results.push_back(item_known ? item_known_result : predicted);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		ttms_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: event_res %0d", result.event_res);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (result.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, result.event_res);
					failures++;
				end
				if (result.chosen_category !== want.chosen_category) begin
					$error("chosen_category: expected %0d, got %0d",
						want.chosen_category, result.chosen_category);
					failures++;
				end
				if (result.message_index !== want.message_index) begin
					$error("message_index: expected %0d, got %0d",
						want.message_index, result.message_index);
					failures++;
				end
				if (result.sequence_number !== want.sequence_number) begin
					$error("sequence_number: expected %0h, got %0h",
						want.sequence_number, result.sequence_number);
					failures++;
				end
				event_tally[want.event_res]++;
				results_checked++;
			end
		end
	end

	// receiver: random stall, plus one long hold-off so the block backs up
	initial begin : receiver
		int stall_left;
		int calm;
		bit held;
		stall_left = 0;
		calm = 0;
		held = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_checked >= 200) begin
				held = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0) begin
				stall_left = pick_gap(calm);
			end
			result_stall = (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("run exceeded %0d cycles, %0d results outstanding",
				CYCLE_LIMIT, expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		table_row_t  directed [$];
		logic [31:0] now;
		logic [31:0] span;
		logic [31:0] pick;
		int roll;
		int rounds;

		item_valid = 1'b0;
		item = '0;
		item_known = 1'b0;
		item_known_result = '0;
		cfg_we = 1'b0;
		cfg_index = ttms_pkg::CFG_NUM_CATEGORIES;
		cfg_data = '0;
		send_calm = 0;
		failures = 0;
		offered = 0;
		results_checked = 0;
		phases = 0;
		cycles = 0;
		event_tally = '{default: 0};

		// predictor reset state
		cat_used = ttms_pkg::NUM_CATEGORIES_RST;
		round_len = ttms_pkg::HYPER_PERIOD_RST;
		seq_next = ttms_pkg::START_SEQUENCE_RST;
		round_stop = '0;
		for (int i = 0; i < SLOTS; i++) begin
			cat_step[i] = '0;
			cat_quota[i] = '0;
			msg_next[i] = '0;
			win_open[i] = '0;
			win_close[i] = '0;
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ticks before any start, unknown mode
		directed.push_back(known(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'd0),
			ttms_pkg::EV_ROUND_OVER));
		directed.push_back(known(item_row(ttms_pkg::MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF,
			32'hFFFFFFFF), ttms_pkg::EV_ROUND_OVER));
		directed.push_back(known(item_row(MODE_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF),
			ttms_pkg::EV_NONE));
		// count above the maximum, short round, sequence about to wrap
		directed.push_back(cfg_row(ttms_pkg::CFG_NUM_CATEGORIES, 32'd15));
		directed.push_back(cfg_row(ttms_pkg::CFG_HYPER_PERIOD, 32'd100));
		directed.push_back(cfg_row(ttms_pkg::CFG_START_SEQUENCE, 32'hFFFFFFFF));
		// load every category: zero count, zero limit, largest count and limit
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd0, 16'd0, 16'd3, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd1, 16'd2, 16'd0, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd2, 16'd4, 16'd2, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd3, 16'hFFFF, 16'hFFFF,
			32'd0), ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd4, 16'd10, 16'd1, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd5, 16'd10, 16'd1, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd6, 16'd1, 16'd2, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_LOAD, 3'd7, 16'd50, 16'd5, 32'd0),
			ttms_pkg::EV_NONE));
		// round that wraps past zero
		directed.push_back(known(item_row(ttms_pkg::MODE_START, 3'd0, 16'd0, 16'd0,
			32'hFFFFFFF0), ttms_pkg::EV_NONE));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'hFFFFFFF0));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'hFFFFFFF1));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'hFFFFFFF8));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'h00000010));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'h00000053));
		directed.push_back(known(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0,
			32'h00000054), ttms_pkg::EV_ROUND_OVER));
		// no category in use
		directed.push_back(cfg_row(ttms_pkg::CFG_NUM_CATEGORIES, 32'd0));
		directed.push_back(known(item_row(ttms_pkg::MODE_START, 3'd0, 16'd0, 16'd0, 32'd5),
			ttms_pkg::EV_NONE));
		directed.push_back(known(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'd6),
			ttms_pkg::EV_NONE));
		// all categories, longest round
		directed.push_back(cfg_row(ttms_pkg::CFG_NUM_CATEGORIES, 32'd8));
		directed.push_back(cfg_row(ttms_pkg::CFG_HYPER_PERIOD, 32'hFFFFFFFF));
		directed.push_back(cfg_row(ttms_pkg::CFG_START_SEQUENCE, 32'd0));
		directed.push_back(known(item_row(ttms_pkg::MODE_START, 3'd0, 16'd0, 16'd0, 32'd0),
			ttms_pkg::EV_NONE));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'hFFFFFFFE));
		directed.push_back(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0, 32'd1));
		directed.push_back(known(item_row(ttms_pkg::MODE_TICK, 3'd0, 16'd0, 16'd0,
			32'hFFFFFFFF), ttms_pkg::EV_ROUND_OVER));

		foreach (directed[r]) begin
			if (directed[r].is_cfg) begin
				settle();
				write_reg(directed[r].cfg_sel, directed[r].cfg_val);
			end else begin
				offer_item(directed[r].it, directed[r].known, directed[r].want);
			end
		end

		// random phases: new settings, then rounds of loads, a start and ticks
		while (offered < ITEMS) begin
			phases++;
			settle();
			roll = $urandom_range(0, 99);
			if (roll < 4)
				pick = 32'd0;
			else if (roll < 8)
				pick = 32'd15;
			else if (roll < 12)
				pick = $urandom_range(9, 15);
			else if (roll < 40)
				pick = 32'd8;
			else
				pick = $urandom_range(1, 8);
			write_reg(ttms_pkg::CFG_NUM_CATEGORIES, pick);
			roll = $urandom_range(0, 99);
			if (roll < 5)
				pick = 32'd1;
			else if (roll < 10)
				pick = 32'hFFFFFFFF;
			else if (roll < 15)
				pick = $urandom;
			else
				pick = $urandom_range(4, 4000);
			write_reg(ttms_pkg::CFG_HYPER_PERIOD, pick);
			if ($urandom_range(0, 1) == 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 20)
					pick = 32'hFFFFFFFF - $urandom_range(0, 5);
				else if (roll < 30)
					pick = 32'd0;
				else
					pick = $urandom;
				write_reg(ttms_pkg::CFG_START_SEQUENCE, pick);
			end

			span = (round_len >> 4) == 32'd0 ? 32'd1 : (round_len >> 4);
			rounds = $urandom_range(1, 3);
			repeat (rounds) begin
				table_row_t row;
				repeat ($urandom_range(1, 8)) begin
					row = item_row(ttms_pkg::MODE_LOAD, 3'($urandom_range(0, 7)), 16'd0, 16'd0,
						$urandom);
					roll = $urandom_range(0, 99);
					row.it.period_count = (roll < 15) ? 16'($urandom) :
						(roll < 20) ? 16'd0 : 16'($urandom_range(1, 16));
					roll = $urandom_range(0, 99);
					row.it.message_limit = (roll < 10) ? 16'd0 :
						(roll < 20) ? 16'($urandom) : 16'($urandom_range(1, 12));
					offer_item(row.it, 1'b0, '0);
				end

				roll = $urandom_range(0, 99);
				if (roll < 15)
					now = 32'hFFFFFFFF - $urandom_range(0, 2000);
				else if (roll < 25)
					now = 32'd0;
				else
					now = $urandom;
				row = item_row(ttms_pkg::MODE_START, 3'($urandom), 16'($urandom), 16'($urandom),
					now);
				offer_item(row.it, 1'b0, '0);

				repeat ($urandom_range(8, 60)) begin
					roll = $urandom_range(0, 99);
					if (roll < 85) begin
						now = now + $urandom_range(0, span);
						row = item_row(ttms_pkg::MODE_TICK, 3'($urandom), 16'($urandom),
							16'($urandom), now);
					end else if (roll < 89) begin
						row = item_row(ttms_pkg::MODE_TICK, 3'($urandom), 16'($urandom),
							16'($urandom), $urandom);
					end else if (roll < 93) begin
						row = item_row(MODE_UNUSED, 3'($urandom), 16'($urandom),
							16'($urandom), $urandom);
					end else if (roll < 97) begin
						row = item_row(ttms_pkg::MODE_LOAD, 3'($urandom),
							16'($urandom_range(0, 16)), 16'($urandom_range(0, 12)), $urandom);
					end else begin
						row = item_row(ttms_pkg::MODE_START, 3'($urandom), 16'($urandom),
							16'($urandom), now);
					end
					offer_item(row.it, 1'b0, '0);
				end
			end
		end

		// drain and finish
		settle();
		repeat (50) @(negedge clk);
		$display("%0d items over %0d random setting phases, %0d results checked",
			offered, phases, results_checked);
		$display("events seen: %0d none, %0d sent, %0d missed, %0d round over",
			event_tally[ttms_pkg::EV_NONE], event_tally[ttms_pkg::EV_SEND],
			event_tally[ttms_pkg::EV_MISS], event_tally[ttms_pkg::EV_ROUND_OVER]);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> time_table_message_scheduler_unit.f
+incdir+hdl
hdl/ttms_pkg.sv
hdl/time_table_message_scheduler_unit.sv
hdl/ttms_checker.sv
test/tb_time_table_message_scheduler_unit.sv
